@@ hw/rtl/sync_pdo_scheduler_unit_defines.svh @@
// assertion macros shared by the scheduler rtl
`ifndef SYNC_PDO_SCHEDULER_UNIT_DEFINES_SVH
`define SYNC_PDO_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define SPS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define SPS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SPS_ASSERT(name, prop, msg)
`define SPS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ hw/rtl/sps_pkg.sv @@
// types and constants of the sync pdo scheduler
`timescale 1ns / 1ps
package sps_pkg;

   localparam int TX_SLOTS  = 8;
   localparam int RX_SLOTS  = 8;
   localparam int NUM_RES   = TX_SLOTS + RX_SLOTS;
   localparam int TX_IDX_W  = $clog2(TX_SLOTS);
   localparam int RX_IDX_W  = $clog2(RX_SLOTS);
   localparam int RES_IDX_W = $clog2(NUM_RES);
   localparam int SLOT_W    = 3;
   localparam int ID_W      = 32;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int PER_W     = 8;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // request operation codes
   localparam logic [2:0] OP_FRAME   = 3'd0;
   localparam logic [2:0] OP_ADD_TX  = 3'd1;
   localparam logic [2:0] OP_ADD_RX  = 3'd2;
   localparam logic [2:0] OP_DEL_TX  = 3'd3;
   localparam logic [2:0] OP_DEL_RX  = 3'd4;
   localparam logic [2:0] OP_RESTART = 3'd5;

   // result kinds
   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   typedef enum logic [2:0] {
      CMD_STORE,
      CMD_SYNC,
      CMD_ADD_TX,
      CMD_ADD_RX,
      CMD_DEL_TX,
      CMD_DEL_RX,
      CMD_RESTART
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [ID_W-1:0]    frame_id;
      logic [LEN_W-1:0]   length;
      logic [DATA_W-1:0]  data;
      logic [SLOT_W-1:0]  slot;
      logic [PER_W-1:0]   period;
      logic [ID_W-1:0]    match_id;
   } cmd_type;

endpackage

@@ hw/rtl/sps_cmd_queue.sv @@
// two-entry command queue between front and back
`timescale 1ns / 1ps
module sps_cmd_queue import sps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        push_cmd,
   input  logic           pop,
   output cmd_type        head_cmd,
   output logic           full,
   output logic           empty
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/sps_front.sv @@
// request decode, sync id compare and csr register
`timescale 1ns / 1ps
module sps_front import sps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [2:0]         req_operation,
   input  logic [ID_W-1:0]    req_frame_id,
   input  logic [LEN_W-1:0]   req_frame_length,
   input  logic [DATA_W-1:0]  req_frame_data,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [PER_W-1:0]   req_tx_period,
   input  logic [ID_W-1:0]    req_rx_match_id,
   input  logic               csr_write_en,
   input  logic [ID_W-1:0]    csr_write_data,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic [ID_W-1:0] sync_id_ff;
   logic            op_known;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_id_ff <= '0;
      end else if (csr_write_en) begin
         sync_id_ff <= csr_write_data;
      end
   end

   assign full = q_full;

   always_comb begin
      op_known = 1'b1;
      q_cmd.op = CMD_STORE;
      unique case (req_operation)
         OP_FRAME: begin
            q_cmd.op = (req_frame_id == sync_id_ff) ? CMD_SYNC : CMD_STORE;
         end
         OP_ADD_TX:  q_cmd.op = CMD_ADD_TX;
         OP_ADD_RX:  q_cmd.op = CMD_ADD_RX;
         OP_DEL_TX:  q_cmd.op = CMD_DEL_TX;
         OP_DEL_RX:  q_cmd.op = CMD_DEL_RX;
         OP_RESTART: q_cmd.op = CMD_RESTART;
         default:    op_known = 1'b0;
      endcase
      q_cmd.frame_id = req_frame_id;
      q_cmd.length   = req_frame_length;
      q_cmd.data     = req_frame_data;
      q_cmd.slot     = req_slot;
      q_cmd.period   = req_tx_period;
      q_cmd.match_id = req_rx_match_id;
   end

   // unused operation codes are taken and dropped here
   assign q_push = push && !q_full && op_known;

endmodule

@@ hw/rtl/sps_back.sv @@
// slot table, command execution and result sequencing
`timescale 1ns / 1ps
`include "sync_pdo_scheduler_unit_defines.svh"
module sps_back import sps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  logic               pop,
   output logic               empty,
   output logic               rsp_kind,
   output logic [SLOT_W-1:0]  rsp_out_slot,
   output logic [LEN_W-1:0]   rsp_out_length,
   output logic [DATA_W-1:0]  rsp_out_data,
   output logic               rsp_last
);

   typedef enum logic {IDLE, EMIT} state_type;

   state_type              state_ff, state_in;
   logic [NUM_RES-1:0]     pending_ff, pending_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff, kind_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic                   last_ff, last_in;

   logic                   tx_en_ff  [TX_SLOTS];
   logic [PER_W-1:0]       tx_per_ff [TX_SLOTS];
   logic [PER_W-1:0]       tx_cnt_ff [TX_SLOTS];
   logic                   rx_en_ff  [RX_SLOTS];
   logic [ID_W-1:0]        rx_id_ff  [RX_SLOTS];
   logic [LEN_W-1:0]       rx_len_ff [RX_SLOTS];
   logic [DATA_W-1:0]      rx_data_ff[RX_SLOTS];

   logic [PER_W-1:0]       cnt_inc [TX_SLOTS];
   logic [TX_SLOTS-1:0]    fire;
   logic [RX_SLOTS-1:0]    rx_en_vec;
   logic [RX_SLOTS-1:0]    rx_hit;
   logic [RX_IDX_W-1:0]    hit_idx;
   logic [RES_IDX_W-1:0]   sel;
   logic [RX_IDX_W-1:0]    sel_rx;
   logic [NUM_RES-1:0]     pending_rest;
   logic                   out_load;
   logic                   tx_slot_ok, rx_slot_ok;
   logic [TX_IDX_W-1:0]    tx_idx;
   logic [RX_IDX_W-1:0]    rx_idx;

   assign cmd_pop    = (state_ff == IDLE) && !cmd_empty;
   assign out_load   = (state_ff == EMIT) && (!rsp_valid_ff || pop);
   assign tx_slot_ok = 32'(cmd.slot) < TX_SLOTS;
   assign rx_slot_ok = 32'(cmd.slot) < RX_SLOTS;
   assign tx_idx     = cmd.slot[TX_IDX_W-1:0];
   assign rx_idx     = cmd.slot[RX_IDX_W-1:0];

   // sync: per-slot counter step and fire test
   always_comb begin
      for (int i = 0; i < TX_SLOTS; i++) begin
         cnt_inc[i] = tx_cnt_ff[i] + 1'b1;
         fire[i]    = tx_en_ff[i] && (tx_per_ff[i] == '0 || cnt_inc[i] == tx_per_ff[i]);
      end
   end

   // frame store: lowest enabled receive slot with matching id
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < RX_SLOTS; i++) begin
         rx_en_vec[i] = rx_en_ff[i];
         rx_hit[i]    = rx_en_ff[i] && (rx_id_ff[i] == cmd.frame_id);
      end
      for (int i = RX_SLOTS - 1; i >= 0; i--) begin
         if (rx_hit[i]) begin
            hit_idx = RX_IDX_W'(i);
         end
      end
   end

   // lowest pending result goes out next
   always_comb begin
      sel = '0;
      for (int i = NUM_RES - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel = RES_IDX_W'(i);
         end
      end
      sel_rx       = RX_IDX_W'(sel - RES_IDX_W'(TX_SLOTS));
      pending_rest = pending_ff & ~(NUM_RES'(1) << sel);
   end

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      len_in       = len_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && pop) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (cmd_pop && cmd.op == CMD_SYNC) begin
               pending_in = {rx_en_vec, fire};
               if ({rx_en_vec, fire} != '0) begin
                  state_in = EMIT;
               end
            end
         end
         EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               last_in      = (pending_rest == '0);
               pending_in   = pending_rest;
               if (32'(sel) < TX_SLOTS) begin
                  kind_in = KIND_TX;
                  slot_in = SLOT_W'(sel);
                  len_in  = '0;
                  data_in = '0;
               end else begin
                  kind_in = KIND_RX;
                  slot_in = SLOT_W'(sel_rx);
                  len_in  = rx_len_ff[sel_rx];
                  data_in = rx_data_ff[sel_rx];
               end
               if (pending_rest == '0) begin
                  state_in = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      slot_ff <= slot_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TX_SLOTS; i++) begin
            tx_en_ff[i]  <= 1'b0;
            tx_per_ff[i] <= '0;
            tx_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < RX_SLOTS; i++) begin
            rx_en_ff[i]   <= 1'b0;
            rx_len_ff[i]  <= '0;
            rx_data_ff[i] <= '0;
         end
      end else if (cmd_pop) begin
         case (cmd.op)
            CMD_STORE: begin
               if (rx_hit != '0) begin
                  rx_len_ff[hit_idx]  <= cmd.length;
                  rx_data_ff[hit_idx] <= cmd.data;
               end
            end
            CMD_SYNC: begin
               for (int i = 0; i < TX_SLOTS; i++) begin
                  if (tx_en_ff[i]) begin
                     tx_cnt_ff[i] <= fire[i] ? '0 : cnt_inc[i];
                  end
               end
            end
            CMD_ADD_TX: begin
               if (tx_slot_ok) begin
                  tx_en_ff[tx_idx]  <= 1'b1;
                  tx_per_ff[tx_idx] <= cmd.period;
                  tx_cnt_ff[tx_idx] <= '0;
               end
            end
            CMD_ADD_RX: begin
               if (rx_slot_ok) begin
                  rx_en_ff[rx_idx] <= 1'b1;
               end
            end
            CMD_DEL_TX: begin
               if (tx_slot_ok) begin
                  tx_en_ff[tx_idx]  <= 1'b0;
                  tx_per_ff[tx_idx] <= '0;
                  tx_cnt_ff[tx_idx] <= '0;
               end
            end
            CMD_DEL_RX: begin
               if (rx_slot_ok) begin
                  rx_en_ff[rx_idx] <= 1'b0;
               end
            end
            CMD_RESTART: begin
               for (int i = 0; i < TX_SLOTS; i++) begin
                  if (tx_en_ff[i]) begin
                     tx_cnt_ff[i] <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // receive ids: no reset, only compared once the slot is enabled
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.op == CMD_ADD_RX && rx_slot_ok) begin
         rx_id_ff[rx_idx] <= cmd.match_id;
      end
   end

   assign empty          = !rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_slot   = slot_ff;
   assign rsp_out_length = len_ff;
   assign rsp_out_data   = data_ff;
   assign rsp_last       = last_ff;

   `SPS_ASSERT(a_emit_has_work, state_ff == EMIT |-> pending_ff != '0, "emit state with nothing pending")
   `SPS_ASSERT(a_last_ends_emit, out_load && pending_rest == '0 |=> state_ff == IDLE && rsp_last, "last result did not end the sync")
   `SPS_ASSERT(a_no_cmd_in_emit, state_ff == EMIT |-> !cmd_pop, "command taken during result sequencing")
   `SPS_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == IDLE && empty, "reset left the back end busy")

endmodule

@@ hw/rtl/sync_pdo_scheduler_unit.sv @@
// top level of the sync pdo scheduler
`timescale 1ns / 1ps
// flow: a taken request waits in the command queue until the idle back end pops it; a sync's
//   first result passes the queue entry, the EMIT state and the result registers, and later
//   results follow one per cycle while pop keeps up; one non-sync request per cycle while the
//   queue has room; a sync yields up to sixteen results, paced by the result sequencer
// reset: synchronous, active high; clears slot enables, periods, counters, buffers, queue and
//   sync identifier, not match ids; no clearing pass, requests are taken right after reset
module sync_pdo_scheduler_unit import sps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               push,
   output logic               full,
   input  logic [2:0]         req_operation,
   input  logic [ID_W-1:0]    req_frame_id,
   input  logic [LEN_W-1:0]   req_frame_length,
   input  logic [DATA_W-1:0]  req_frame_data,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [PER_W-1:0]   req_tx_period,
   input  logic [ID_W-1:0]    req_rx_match_id,
   // result side
   output logic               empty,
   input  logic               pop,
   output logic               rsp_kind,
   output logic [SLOT_W-1:0]  rsp_out_slot,
   output logic [LEN_W-1:0]   rsp_out_length,
   output logic [DATA_W-1:0]  rsp_out_data,
   output logic               rsp_last,
   // sync identifier register
   input  logic               csr_write_en,
   input  logic [ID_W-1:0]    csr_write_data
);

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   cmd_type          q_in_cmd;
   cmd_type          q_head_cmd;

   // front: decodes each request and tags frames as sync or store
   sps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_frame_id     (req_frame_id),
      .req_frame_length (req_frame_length),
      .req_frame_data   (req_frame_data),
      .req_slot         (req_slot),
      .req_tx_period    (req_tx_period),
      .req_rx_match_id  (req_rx_match_id),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_in_cmd)
   );

   // short queue so the front keeps taking requests while a sync drains
   sps_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: slot table updates and the per-sync result sequencer
   sps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (q_head_cmd),
      .cmd_empty      (q_empty),
      .cmd_pop        (q_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_kind       (rsp_kind),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_out_length (rsp_out_length),
      .rsp_out_data   (rsp_out_data),
      .rsp_last       (rsp_last)
   );

endmodule
